// ===== rtl/assert_macros.svh =====
// Assertion macros used by the interpolator controller.
// Each macro expands to one labelled concurrent assertion on a rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bti_pkg.sv =====
// Shared types, constants and helpers for the bilinear table interpolator.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package bti_pkg;

    localparam int DEF_MAX_X_POINTS = 64;
    localparam int DEF_MAX_Y_POINTS = 64;

    localparam int CNT_W = 7;
    // Last count of the 65-step divider and of the 33-step multiplier.
    localparam logic [CNT_W-1:0] DIV_LAST = 7'd64;
    localparam logic [CNT_W-1:0] MUL_LAST = 7'd32;

    // Weight of exactly 1.0 in unsigned Q0.32, carried in 33 bits.
    localparam logic [32:0] WEIGHT_ONE = 33'h1_0000_0000;

    localparam logic [6:0] RST_POINTS = 7'd64;

    typedef enum logic [1:0] {
        K_GRID   = 2'd0,
        K_XNODE  = 2'd1,
        K_YNODE  = 2'd2,
        K_LOOKUP = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_X_POINTS  = 2'd0,
        CFG_Y_POINTS  = 2'd1,
        CFG_UNIFORM_X = 2'd2,
        CFG_UNIFORM_Y = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        NA_ZERO = 2'd0,
        NA_ONE  = 2'd1,
        NA_NEXT = 2'd2
    } t_node_sel;

    typedef enum logic [1:0] {
        CS_LOW  = 2'd0,
        CS_LAST = 2'd1,
        CS_WALK = 2'd2,
        CS_UNI  = 2'd3
    } t_cell_src;

    typedef enum logic [1:0] {
        GA_00 = 2'd0,
        GA_01 = 2'd1,
        GA_10 = 2'd2,
        GA_11 = 2'd3
    } t_grid_sel;

    typedef struct packed {
        logic      wr_grid;
        logic      wr_xnode;
        logic      wr_ynode;
        logic      ld_query;
        logic      axis;
        t_node_sel node_sel;
        logic      prev_ld;
        logic      k_clr;
        logic      k_inc;
        logic      div_ld;
        logic      div_step;
        logic      cell_ld;
        t_cell_src cell_src;
        t_grid_sel grid_sel;
        logic      ld_a;
        logic      ld_b;
        logic      ld_ab_lohi;
        logic      lerp_ld;
        logic      lerp_step;
        logic      t_sel_x;
        logic      lo_ld;
        logic      hi_ld;
        logic      out_ld;
    } t_cmd;

    typedef struct packed {
        logic q_lt_node;
        logic in_cell;
        logic d_pos;
        logic k_last;
        logic quo_ok;
        logic uni;
    } t_sts;

    // Index of the last cell: the point count clamped to 2..maxn, less two.
    function automatic int last_cell(logic [6:0] pts, int maxn);
        int n;
        n = int'(pts);
        if (n < 2) begin
            n = 2;
        end else if (n > maxn) begin
            n = maxn;
        end
        return n - 2;
    endfunction

endpackage

// ===== rtl/bti_ctrl.sv =====
// Sequencer of the bilinear table interpolator: cell search, division and blends.
// Depends on bti_pkg and assert_macros.svh; drives bti_dpath by command structs.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bti_ctrl import bti_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [1:0] i_kind,
    input  t_sts       i_sts,
    output logic       busy,
    output logic       o_valid,
    output t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_AX_RD0, S_AX_CHK0, S_AX_WALK, S_AX_UNI, S_AX_DIV, S_AX_DIVEND,
        S_AX_NEXT, S_G_A, S_G_B, S_G_CAP, S_L_AB, S_L_LD, S_L_RUN, S_L_END
    } t_state;

    typedef enum logic [1:0] {
        P_LO, P_HI, P_OUT
    } t_pass;

    t_state           r_state, n_state;
    t_pass            r_pass, n_pass;
    logic             r_axis, n_axis;
    logic             r_valid, n_valid;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_cmd             cmd;

    always_comb begin
        cmd      = '0;
        cmd.axis = r_axis;
        n_state  = r_state;
        n_pass   = r_pass;
        n_axis   = r_axis;
        n_valid  = 1'b0;
        n_cnt    = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (t_kind'(i_kind))
                        K_GRID:  cmd.wr_grid  = 1'b1;
                        K_XNODE: cmd.wr_xnode = 1'b1;
                        K_YNODE: cmd.wr_ynode = 1'b1;
                        K_LOOKUP: begin
                            cmd.ld_query = 1'b1;
                            n_axis       = 1'b0;
                            n_state      = S_AX_RD0;
                        end
                        default: ;
                    endcase
                end
            end
            S_AX_RD0: begin
                cmd.node_sel = NA_ZERO;
                n_state      = S_AX_CHK0;
            end
            S_AX_CHK0: begin
                cmd.prev_ld  = 1'b1;
                cmd.k_clr    = 1'b1;
                cmd.node_sel = NA_ONE;
                if (i_sts.q_lt_node) begin
                    cmd.cell_ld  = 1'b1;
                    cmd.cell_src = CS_LOW;
                    n_state      = S_AX_NEXT;
                end else if (i_sts.uni) begin
                    n_state = S_AX_UNI;
                end else begin
                    n_state = S_AX_WALK;
                end
            end
            S_AX_WALK: begin
                priority if (i_sts.in_cell) begin
                    cmd.div_ld = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_AX_DIV;
                end else if (i_sts.k_last) begin
                    cmd.cell_ld  = 1'b1;
                    cmd.cell_src = CS_LAST;
                    n_state      = S_AX_NEXT;
                end else begin
                    cmd.prev_ld  = 1'b1;
                    cmd.k_inc    = 1'b1;
                    cmd.node_sel = NA_NEXT;
                end
            end
            S_AX_UNI: begin
                if (i_sts.d_pos) begin
                    cmd.div_ld = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_AX_DIV;
                end else begin
                    cmd.cell_ld  = 1'b1;
                    cmd.cell_src = CS_LAST;
                    n_state      = S_AX_NEXT;
                end
            end
            S_AX_DIV: begin
                cmd.div_step = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_AX_DIVEND;
                end
            end
            S_AX_DIVEND: begin
                cmd.cell_ld = 1'b1;
                if (!i_sts.uni) begin
                    cmd.cell_src = CS_WALK;
                end else if (i_sts.quo_ok) begin
                    cmd.cell_src = CS_UNI;
                end else begin
                    cmd.cell_src = CS_LAST;
                end
                n_state = S_AX_NEXT;
            end
            S_AX_NEXT: begin
                if (!r_axis) begin
                    n_axis  = 1'b1;
                    n_state = S_AX_RD0;
                end else begin
                    n_pass  = P_LO;
                    n_state = S_G_A;
                end
            end
            S_G_A: begin
                cmd.grid_sel = (r_pass == P_LO) ? GA_00 : GA_10;
                n_state      = S_G_B;
            end
            S_G_B: begin
                cmd.grid_sel = (r_pass == P_LO) ? GA_01 : GA_11;
                cmd.ld_a     = 1'b1;
                n_state      = S_G_CAP;
            end
            S_G_CAP: begin
                cmd.ld_b = 1'b1;
                n_state  = S_L_LD;
            end
            S_L_AB: begin
                cmd.ld_ab_lohi = 1'b1;
                n_state        = S_L_LD;
            end
            S_L_LD: begin
                cmd.lerp_ld = 1'b1;
                cmd.t_sel_x = (r_pass == P_OUT);
                n_cnt       = '0;
                n_state     = S_L_RUN;
            end
            S_L_RUN: begin
                cmd.lerp_step = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == MUL_LAST) begin
                    n_state = S_L_END;
                end
            end
            S_L_END: begin
                unique case (r_pass)
                    P_LO: begin
                        cmd.lo_ld = 1'b1;
                        n_pass    = P_HI;
                        n_state   = S_G_A;
                    end
                    P_HI: begin
                        cmd.hi_ld = 1'b1;
                        n_pass    = P_OUT;
                        n_state   = S_L_AB;
                    end
                    default: begin
                        cmd.out_ld = 1'b1;
                        n_valid    = 1'b1;
                        n_state    = S_IDLE;
                    end
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= P_LO;
            r_axis  <= 1'b0;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
            r_axis  <= n_axis;
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_cmd   = cmd;

    `ASSERT_IMPLY(a_valid_idle, i_clk, i_rst_n, r_valid, r_state == S_IDLE,
        "result strobe outside the idle state")
    `ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, r_valid, !r_valid,
        "result strobe longer than one cycle")
    `ASSERT_NEXT(a_lookup_start, i_clk, i_rst_n,
        start && !busy && (i_kind == K_LOOKUP), r_state == S_AX_RD0 && !r_axis,
        "accepted lookup did not start the x axis search")
    `ASSERT_IMPLY(a_write_no_busy, i_clk, i_rst_n,
        o_cmd.wr_grid || o_cmd.wr_xnode || o_cmd.wr_ynode, !busy,
        "store write issued while busy")

endmodule

// ===== rtl/bti_dpath.sv =====
// Datapath of the bilinear table interpolator: stores, divider, multiplier, blends.
// Depends on bti_pkg; bti_ctrl commands order all steps but configuration writes.
`timescale 1ns / 1ps

module bti_dpath import bti_pkg::*; #(
    parameter int MAX_X_POINTS = DEF_MAX_X_POINTS,
    parameter int MAX_Y_POINTS = DEF_MAX_Y_POINTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [6:0]         i_cfg_data,
    input  logic [5:0]         i_row_index,
    input  logic [5:0]         i_col_index,
    input  logic signed [31:0] i_write_value,
    input  logic signed [31:0] i_query_x,
    input  logic signed [31:0] i_query_y,
    output logic signed [31:0] o_interpolated
);

    localparam int XW = (MAX_X_POINTS > 1) ? $clog2(MAX_X_POINTS) : 1;
    localparam int YW = (MAX_Y_POINTS > 1) ? $clog2(MAX_Y_POINTS) : 1;
    localparam int KW = (XW > YW) ? XW : YW;
    localparam int GDEPTH = MAX_X_POINTS * MAX_Y_POINTS;
    localparam int GW = $clog2(GDEPTH);

    // Configuration.
    logic [6:0] r_x_points, r_y_points;
    logic       r_uni_x, r_uni_y;

    // Stores.
    logic signed [31:0] r_grid_mem [GDEPTH];
    logic signed [31:0] r_xmem [MAX_X_POINTS];
    logic signed [31:0] r_ymem [MAX_Y_POINTS];
    logic signed [31:0] r_grid_q, r_xq, r_yq;

    // Search and division.
    logic signed [31:0] r_qx, r_qy, r_prev;
    logic [KW-1:0]      r_k;
    logic [32:0]        r_rem, r_den;
    logic [64:0]        r_quo;
    logic [XW-1:0]      r_cell_x;
    logic [YW-1:0]      r_cell_y;
    logic [32:0]        r_tx, r_ty;

    // Blending.
    logic signed [31:0] r_a, r_b, r_lo, r_hi, r_out;
    logic               r_neg;
    logic [32:0]        r_mag, r_tsh;
    logic [65:0]        r_acc;

    logic [XW-1:0]      last_x;
    logic [YW-1:0]      last_y;
    logic [KW-1:0]      last_k, node_addr, cell_v;
    logic signed [31:0] q_sel, node_cur;
    logic signed [32:0] num, node_gap, diff;
    logic [33:0]        trial;
    logic               trial_ge;
    logic [32:0]        t_v, t_l;
    logic               row_ok, col_ok;
    logic [XW-1:0]      gi;
    logic [YW-1:0]      gj;
    logic [GW-1:0]      g_rd_addr, g_wr_addr;
    logic [33:0]        prod_hi;
    logic signed [33:0] blend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_points <= RST_POINTS;
            r_y_points <= RST_POINTS;
            r_uni_x    <= 1'b1;
            r_uni_y    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_X_POINTS:  r_x_points <= i_cfg_data;
                CFG_Y_POINTS:  r_y_points <= i_cfg_data;
                CFG_UNIFORM_X: r_uni_x    <= i_cfg_data[0];
                CFG_UNIFORM_Y: r_uni_y    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign last_x = XW'(last_cell(r_x_points, MAX_X_POINTS));
    assign last_y = YW'(last_cell(r_y_points, MAX_Y_POINTS));
    assign last_k = i_cmd.axis ? KW'(last_y) : KW'(last_x);

    assign row_ok = int'(i_row_index) < MAX_X_POINTS;
    assign col_ok = int'(i_col_index) < MAX_Y_POINTS;

    always_comb begin
        unique case (i_cmd.node_sel)
            NA_ZERO: node_addr = '0;
            NA_ONE:  node_addr = KW'(1);
            NA_NEXT: node_addr = r_k + KW'(2);
            default: node_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_xnode && row_ok) begin
            r_xmem[XW'(i_row_index)] <= i_write_value;
        end
        r_xq <= r_xmem[XW'(node_addr)];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_ynode && col_ok) begin
            r_ymem[YW'(i_col_index)] <= i_write_value;
        end
        r_yq <= r_ymem[YW'(node_addr)];
    end

    // Row-major grid, row is the x index.
    always_comb begin
        gi = r_cell_x;
        gj = r_cell_y;
        if (i_cmd.grid_sel == GA_10 || i_cmd.grid_sel == GA_11) begin
            gi = r_cell_x + 1'b1;
        end
        if (i_cmd.grid_sel == GA_01 || i_cmd.grid_sel == GA_11) begin
            gj = r_cell_y + 1'b1;
        end
    end

    assign g_rd_addr = GW'(GW'(gi) * GW'(MAX_Y_POINTS) + GW'(gj));
    assign g_wr_addr = GW'(GW'(XW'(i_row_index)) * GW'(MAX_Y_POINTS)
                       + GW'(YW'(i_col_index)));

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_grid && row_ok && col_ok) begin
            r_grid_mem[g_wr_addr] <= i_write_value;
        end
        r_grid_q <= r_grid_mem[g_rd_addr];
    end

    // Cell search.
    assign q_sel    = i_cmd.axis ? r_qy : r_qx;
    assign node_cur = i_cmd.axis ? r_yq : r_xq;
    assign num      = {q_sel[31], q_sel} - {r_prev[31], r_prev};
    assign node_gap = {node_cur[31], node_cur} - {r_prev[31], r_prev};

    assign o_sts.q_lt_node = q_sel < node_cur;
    assign o_sts.in_cell   = (r_prev <= q_sel) && (q_sel < node_cur);
    assign o_sts.d_pos     = !node_gap[32] && (node_gap != '0);
    assign o_sts.k_last    = (r_k == last_k);
    assign o_sts.quo_ok    = r_quo[64:32] <= 33'(last_k);
    assign o_sts.uni       = i_cmd.axis ? r_uni_y : r_uni_x;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_query) begin
            r_qx <= i_query_x;
            r_qy <= i_query_y;
        end
        if (i_cmd.prev_ld) begin
            r_prev <= node_cur;
        end
        if (i_cmd.k_clr) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + 1'b1;
        end
    end

    // Restoring divider, one quotient bit a cycle: (num << 32) / node_gap.
    assign trial    = {r_rem, r_quo[64]};
    assign trial_ge = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_ld) begin
            r_rem <= '0;
            r_den <= node_gap;
            r_quo <= {num, 32'd0};
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? 33'(trial - {1'b0, r_den}) : trial[32:0];
            r_quo <= {r_quo[63:0], trial_ge};
        end
    end

    // The upper quotient bits are the uniform cell, the lower ones the weight.
    always_comb begin
        unique case (i_cmd.cell_src)
            CS_LOW: begin
                cell_v = '0;
                t_v    = '0;
            end
            CS_LAST: begin
                cell_v = last_k;
                t_v    = WEIGHT_ONE;
            end
            CS_WALK: begin
                cell_v = r_k;
                t_v    = {1'b0, r_quo[31:0]};
            end
            CS_UNI: begin
                cell_v = r_quo[32+KW-1:32];
                t_v    = {1'b0, r_quo[31:0]};
            end
            default: begin
                cell_v = '0;
                t_v    = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cell_ld) begin
            if (i_cmd.axis) begin
                r_cell_y <= YW'(cell_v);
                r_ty     <= t_v;
            end else begin
                r_cell_x <= XW'(cell_v);
                r_tx     <= t_v;
            end
        end
    end

    // Blend a towards b by the weight, truncating towards a; shift-add multiply.
    assign t_l     = i_cmd.t_sel_x ? r_tx : r_ty;
    assign diff    = {r_b[31], r_b} - {r_a[31], r_a};
    assign prod_hi = r_acc[65:32];
    assign blend   = r_neg ? ({{2{r_a[31]}}, r_a} - signed'(prod_hi))
                           : ({{2{r_a[31]}}, r_a} + signed'(prod_hi));

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_a) begin
            r_a <= r_grid_q;
        end else if (i_cmd.ld_ab_lohi) begin
            r_a <= r_lo;
        end
        if (i_cmd.ld_b) begin
            r_b <= r_grid_q;
        end else if (i_cmd.ld_ab_lohi) begin
            r_b <= r_hi;
        end
        if (i_cmd.lerp_ld) begin
            r_neg <= diff[32];
            r_mag <= diff[32] ? 33'(-diff) : 33'(diff);
            r_acc <= '0;
            r_tsh <= t_l;
        end else if (i_cmd.lerp_step) begin
            r_acc <= {r_acc[64:0], 1'b0} + (r_tsh[32] ? 66'(r_mag) : 66'd0);
            r_tsh <= {r_tsh[31:0], 1'b0};
        end
        if (i_cmd.lo_ld) begin
            r_lo <= blend[31:0];
        end
        if (i_cmd.hi_ld) begin
            r_hi <= blend[31:0];
        end
        if (i_cmd.out_ld) begin
            r_out <= blend[31:0];
        end
    end

    assign o_interpolated = r_out;

endmodule

// ===== rtl/bilinear_table_interpolator.sv =====
// Channel     Signals                                               Transfer
// ----------  ----------------------------------------------------  ------------------------
// command     start, busy, i_kind, i_row_index, i_col_index,         start && !busy
//             i_write_value, i_query_x, i_query_y
// result      o_valid, o_interpolated                               o_valid, one cycle
// config      i_cfg_we, i_cfg_idx, i_cfg_data                       i_cfg_we
//
// Store writes leave busy low. A lookup searches x, then y: a uniform axis is set by the
// 65-step shared divider unless its step is not positive; a searched axis walks one node
// a cycle, then divides once it finds the cell; a query below the first node does neither.
// The three blends then run on the serial 33-step multiplier, and the result comes in the
// same cycle as busy falls. Synchronous active-low reset clears the controller and the
// configuration; the stores hold no defined contents until written. The result receiver
// cannot stall.
// Depends on bti_pkg, bti_ctrl and bti_dpath.
`timescale 1ns / 1ps

module bilinear_table_interpolator import bti_pkg::*; #(
    parameter int MAX_X_POINTS = DEF_MAX_X_POINTS,
    parameter int MAX_Y_POINTS = DEF_MAX_Y_POINTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_kind,
    input  logic [5:0]         i_row_index,
    input  logic [5:0]         i_col_index,
    input  logic signed [31:0] i_write_value,
    input  logic signed [31:0] i_query_x,
    input  logic signed [31:0] i_query_y,
    output logic               o_valid,
    output logic signed [31:0] o_interpolated,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [6:0]         i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    bti_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_kind  (i_kind),
        .i_sts   (sts),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    bti_dpath #(
        .MAX_X_POINTS (MAX_X_POINTS),
        .MAX_Y_POINTS (MAX_Y_POINTS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_row_index    (i_row_index),
        .i_col_index    (i_col_index),
        .i_write_value  (i_write_value),
        .i_query_x      (i_query_x),
        .i_query_y      (i_query_y),
        .o_interpolated (o_interpolated)
    );

endmodule

// ===== tb/sv/tb_bilinear_table_interpolator.sv =====
// Self-checking testbench for bilinear_table_interpolator: fills the stores, runs directed
// and random lookups across several configurations, and checks every result in order.
// Depends on bti_pkg and the bilinear_table_interpolator RTL.
`timescale 1ns / 1ps

module tb_bilinear_table_interpolator import bti_pkg::*; ();

    localparam int  CYCLE_LIMIT = 3_000_000;
    localparam int  GRID_COLS   = 64;
    localparam int  AXIS_MAX    = 64;
    // Random phases keep their point counts within the filled corner of the grid.
    localparam int  GRID_FILL   = 24;
    localparam longint unsigned UNIT_WEIGHT = 64'h1_0000_0000;

    typedef longint unsigned t_u64;

    typedef struct {
        t_kind              kind;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] value;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
    } t_table_cmd;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_kind = '0;
    logic [5:0]         i_row_index = '0;
    logic [5:0]         i_col_index = '0;
    logic signed [31:0] i_write_value = '0;
    logic signed [31:0] i_query_x = '0;
    logic signed [31:0] i_query_y = '0;
    logic               o_valid;
    logic signed [31:0] o_interpolated;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [6:0]         i_cfg_data = '0;

    bilinear_table_interpolator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_kind(i_kind), .i_row_index(i_row_index), .i_col_index(i_col_index),
        .i_write_value(i_write_value), .i_query_x(i_query_x), .i_query_y(i_query_y),
        .o_valid(o_valid), .o_interpolated(o_interpolated),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the table and its configuration.
    longint     grid_shadow [GRID_COLS*GRID_COLS];
    longint     xnode_shadow [AXIS_MAX];
    longint     ynode_shadow [AXIS_MAX];
    logic [6:0] xpts_shadow = RST_POINTS;
    logic [6:0] ypts_shadow = RST_POINTS;
    bit         xuni_shadow = 1'b1;
    bit         yuni_shadow = 1'b1;

    t_table_cmd         pending_cmds [$];
    logic signed [31:0] expected_values [$];
    int                 mismatches = 0;
    int                 cycles = 0;
    int                 idle_left = 0;
    bit                 took = 1'b0;
    bit                 quiet = 1'b0;

    function automatic int points_in_use(logic [6:0] pts);
        if (pts < 2) return 2;
        if (pts > AXIS_MAX) return AXIS_MAX;
        return int'(pts);
    endfunction

    function automatic longint node_of(bit is_x, int k);
        return is_x ? xnode_shadow[k] : ynode_shadow[k];
    endfunction

    // Cell index and Q0.32 weight of the upper node along one axis.
    function automatic void find_axis_cell(input bit is_x, input longint q,
                                           output int cell_idx, output longint unsigned w);
        int n;
        bit uni;
        longint d;
        longint unsigned diff, idx, rem;
        n = points_in_use(is_x ? xpts_shadow : ypts_shadow);
        uni = is_x ? xuni_shadow : yuni_shadow;
        if (q < node_of(is_x, 0)) begin
            cell_idx = 0;
            w = 0;
            return;
        end
        if (uni) begin
            d = node_of(is_x, 1) - node_of(is_x, 0);
            if (d > 0) begin
                diff = t_u64'(q - node_of(is_x, 0));
                idx = diff / t_u64'(d);
                if (idx < t_u64'(n - 1)) begin
                    rem = diff - idx * t_u64'(d);
                    cell_idx = int'(idx);
                    w = (rem << 32) / t_u64'(d);
                    return;
                end
            end
        end else begin
            for (int k = 0; k + 1 < n; k++) begin
                if (node_of(is_x, k) <= q && q < node_of(is_x, k + 1)) begin
                    diff = t_u64'(q - node_of(is_x, k));
                    cell_idx = k;
                    w = (diff << 32) / t_u64'(node_of(is_x, k + 1) - node_of(is_x, k));
                    return;
                end
            end
        end
        cell_idx = n - 2;
        w = UNIT_WEIGHT;
    endfunction

    // Blend that truncates toward a.
    function automatic longint blend(longint a, longint b, longint unsigned w);
        longint d;
        d = b - a;
        if (d >= 0) return a + longint'((t_u64'(d) * w) >> 32);
        return a - longint'((t_u64'(-d) * w) >> 32);
    endfunction

    function automatic logic signed [31:0] interpolate_at(logic signed [31:0] qx,
                                                         logic signed [31:0] qy);
        int i, j;
        longint unsigned tx, ty;
        longint lo, hi, r;
        find_axis_cell(1'b1, longint'(qx), i, tx);
        find_axis_cell(1'b0, longint'(qy), j, ty);
        lo = blend(grid_shadow[i*GRID_COLS + j], grid_shadow[i*GRID_COLS + j + 1], ty);
        hi = blend(grid_shadow[(i+1)*GRID_COLS + j], grid_shadow[(i+1)*GRID_COLS + j + 1], ty);
        r = blend(lo, hi, tx);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    // Result checking and prediction of each accepted command.
    always @(posedge i_clk) begin
        t_table_cmd c;
        logic signed [31:0] want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout waiting for results");
            $display("tb_bilinear_table_interpolator NOT OK");
            $finish;
        end else begin
            if (i_rst_n && o_valid) begin
                if (expected_values.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", o_interpolated));
                end else begin
                    want = expected_values.pop_front();
                    if (o_interpolated !== want)
                        report_mismatch($sformatf("interpolated %h, expected %h",
                                                  o_interpolated, want));
                end
            end
            took = i_rst_n && start && !busy;
            if (took) begin
                c.kind = t_kind'(i_kind);
                c.row = i_row_index;
                c.col = i_col_index;
                c.value = i_write_value;
                case (c.kind)
                    K_GRID:  grid_shadow[int'(c.row)*GRID_COLS + int'(c.col)] = longint'(c.value);
                    K_XNODE: xnode_shadow[c.row] = longint'(c.value);
                    K_YNODE: ynode_shadow[c.col] = longint'(c.value);
                    default: expected_values.push_back(interpolate_at(i_query_x, i_query_y));
                endcase
            end
        end
    end

    // Command driver: holds each command until the transfer, with random gaps unless quiet.
    always @(negedge i_clk) begin
        t_table_cmd c;
        if (i_rst_n && (!start || took)) begin
            if (idle_left > 0) begin
                idle_left--;
                start <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                c = pending_cmds.pop_front();
                i_kind <= c.kind;
                i_row_index <= c.row;
                i_col_index <= c.col;
                i_write_value <= c.value;
                i_query_x <= c.qx;
                i_query_y <= c.qy;
                start <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0) idle_left = $urandom_range(1, 5);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Unused fields carry noise.
    task automatic queue_write(t_kind kind, int row, int col, logic signed [31:0] value);
        t_table_cmd c;
        c.kind = kind;
        c.row = row[5:0];
        c.col = col[5:0];
        c.value = value;
        c.qx = $urandom;
        c.qy = $urandom;
        pending_cmds.push_back(c);
    endtask

    task automatic queue_lookup(logic signed [31:0] qx, logic signed [31:0] qy);
        t_table_cmd c;
        c.kind = K_LOOKUP;
        c.row = $urandom;
        c.col = $urandom;
        c.value = $urandom;
        c.qx = qx;
        c.qy = qy;
        pending_cmds.push_back(c);
    endtask

    // Waits until every command has gone and every result has come, then lets the
    // block settle before a register write.
    task automatic drain();
        do @(negedge i_clk);
        while (!(pending_cmds.size() == 0 && !start && expected_values.size() == 0 && !busy));
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [6:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_X_POINTS:  xpts_shadow = data;
            CFG_Y_POINTS:  ypts_shadow = data;
            CFG_UNIFORM_X: xuni_shadow = data[0];
            default:       yuni_shadow = data[0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // The mode registers get noise in their unused upper bits.
    task automatic configure(int xp, int yp, bit ux, bit uy);
        drain();
        write_reg(CFG_X_POINTS, xp[6:0]);
        write_reg(CFG_Y_POINTS, yp[6:0]);
        write_reg(CFG_UNIFORM_X, {6'($urandom), ux});
        write_reg(CFG_UNIFORM_Y, {6'($urandom), uy});
    endtask

    function automatic int pick_points();
        int extremes [4] = '{0, 1, 2, GRID_FILL};
        if ($urandom_range(0, 3) == 0) return extremes[$urandom_range(0, 3)];
        return $urandom_range(2, GRID_FILL);
    endfunction

    // Mostly increasing nodes; now and then a broken order or a step that is not positive.
    task automatic load_axis(bit is_x);
        longint v, step;
        int sh;
        v = longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824;
        sh = $urandom_range(0, 22);
        for (int k = 0; k < GRID_FILL; k++) begin
            step = longint'($urandom_range(1, 1 << sh));
            if ($urandom_range(0, 15) == 0) step = 0;
            if (k == 1 && $urandom_range(0, 9) == 0) step = -step;
            v = v + step;
            if ($urandom_range(0, 40) == 0)
                queue_write(is_x ? K_XNODE : K_YNODE, k, k, $urandom);
            else
                queue_write(is_x ? K_XNODE : K_YNODE, k, k, sat32(v));
        end
    endtask

    // A coordinate around the span of the axis, sometimes on a node or anywhere at all.
    function automatic logic signed [31:0] pick_coord(bit is_x);
        int n;
        longint lo, hi, span;
        n = points_in_use(is_x ? xpts_shadow : ypts_shadow);
        lo = node_of(is_x, 0);
        if (is_x ? xuni_shadow : yuni_shadow)
            hi = lo + (node_of(is_x, 1) - lo) * (n - 1);
        else
            hi = node_of(is_x, n - 1);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return sat32(node_of(is_x, $urandom_range(0, n - 1)));
            default: begin
                if (hi < lo) hi = lo + 1000;
                span = hi - lo;
                lo = lo - span / 16 - 1;
                span = span + span / 8 + 2;
                return sat32(lo + longint'({$urandom, $urandom} % t_u64'(span)));
            end
        endcase
    endfunction

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Every node entry and the filled corner of the grid are written before any lookup.
        for (int k = 0; k < AXIS_MAX; k++) begin
            queue_write(K_XNODE, k, $urandom, $urandom);
            queue_write(K_YNODE, $urandom, k, $urandom);
        end
        for (int r = 0; r < GRID_FILL; r++)
            for (int c = 0; c < GRID_FILL; c++)
                queue_write(K_GRID, r, c, $urandom);

        // Two by two table with corner extremes.
        configure(2, 2, 1'b1, 1'b1);
        queue_write(K_XNODE, 0, 0, 32'sh0);
        queue_write(K_XNODE, 1, 0, 32'sh1_0000);
        queue_write(K_YNODE, 0, 0, 32'sh0);
        queue_write(K_YNODE, 0, 1, 32'sh1_0000);
        queue_write(K_GRID, 0, 0, 32'sh7FFF_FFFF);
        queue_write(K_GRID, 0, 1, 32'sh8000_0000);
        queue_write(K_GRID, 1, 0, 32'sh8000_0000);
        queue_write(K_GRID, 1, 1, 32'sh7FFF_FFFF);
        queue_lookup(32'sh0, 32'sh0);
        queue_lookup(32'sh8000, 32'sh8000);
        queue_lookup(32'sh1_0000, 32'sh1_0000);
        queue_lookup(-32'sh1, 32'sh5);
        queue_lookup(32'sh7FFF_FFFF, 32'sh8000_0000);
        queue_lookup(32'shFFFF, 32'sh1);
        // Uniform x step of zero: a query below clamps x low, the rest to the last x node.
        queue_write(K_XNODE, 1, 0, 32'sh0);
        queue_lookup(32'sh5, 32'sh5);
        queue_lookup(-32'sh5, 32'sh5);
        // Counts below two act as two; nodes out of order find no cell.
        configure(0, 1, 1'b0, 1'b0);
        queue_write(K_XNODE, 0, 0, 32'sh64);
        queue_write(K_XNODE, 1, 0, -32'sh64);
        queue_lookup(32'sh64, 32'sh8000);
        queue_lookup(32'sh0, 32'sh1_0000);
        // Counts above the maximum act as the maximum. A y step of one puts large
        // queries at the top corner, and the x nodes out of order clamp x to one end.
        configure(127, 65, 1'b0, 1'b1);
        queue_write(K_YNODE, 0, 0, 32'sh0);
        queue_write(K_YNODE, 0, 1, 32'sh1);
        for (int r = 0; r < 4; r++) begin
            queue_write(K_GRID, (r < 2) ? r : r + 60, AXIS_MAX - 2, $urandom);
            queue_write(K_GRID, (r < 2) ? r : r + 60, AXIS_MAX - 1, $urandom);
        end
        queue_lookup(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        queue_lookup(32'sh8000_0000, 32'sh3E);
        queue_lookup(32'sh7FFF_FFFF, 32'sh3F);

        for (int phase = 0; phase < 8; phase++) begin
            configure(pick_points(), pick_points(), $urandom, $urandom);
            if (phase >= 6) quiet = 1'b1;
            load_axis(1'b1);
            load_axis(1'b0);
            for (int k = 0; k < 20; k++)
                queue_write(K_GRID, $urandom, $urandom,
                            $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000) - 1000);
            drain();
            for (int k = 0; k < 90; k++) begin
                if ($urandom_range(0, 5) == 0)
                    queue_write(K_GRID, $urandom, $urandom, $urandom);
                queue_lookup(pick_coord(1'b1), pick_coord(1'b0));
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (expected_values.size() != 0)
            report_mismatch($sformatf("%0d results never came", expected_values.size()));
        if (mismatches == 0) begin
            $display("tb_bilinear_table_interpolator OK");
        end else begin
            $display("tb_bilinear_table_interpolator NOT OK");
        end
        $finish;
    end

endmodule

// ===== bilinear_table_interpolator.f =====
+incdir+rtl
rtl/bti_pkg.sv
rtl/bti_ctrl.sv
rtl/bti_dpath.sv
rtl/bilinear_table_interpolator.sv
tb/sv/tb_bilinear_table_interpolator.sv
